@@ rtl/lis_pkg.sv @@
package lis_pkg;

    localparam int VAL_W = 32;
    localparam int LEN_W = 11;

    // Flipping the sign bit makes unsigned order match signed order.
    localparam logic [VAL_W-1:0] SIGN_FLIP = 32'h8000_0000;

    typedef logic [VAL_W-1:0] t_tail;
    typedef logic [LEN_W-1:0] t_len;

endpackage

@@ rtl/longest_increasing_subsequence.sv @@
// Channel | Direction | Handshake               | Payload
// input   | in        | i_in_valid / o_in_stall | i_value, i_last
// result  | out       | o_out_valid / i_out_stall | o_lis_length, o_overflow
//
// Each element runs a binary search over n, the current table length; each search step
// costs a tail memory read and a compare of the read tail against the element's key.
// Past MAX_ITEMS counted elements an element is dropped; a last one still closes the sequence.
// Reset is synchronous and active low; the tail memory needs no clearing pass.
// A result waits in its own register, so a stalled result holds back only the next sequence's end.
module longest_increasing_subsequence #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [31:0]          i_value,
    input  logic                        i_last,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output lis_pkg::t_len               o_lis_length,
    output logic                        o_overflow
);
    import lis_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ITEMS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PROBE  = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    t_tail r_tail_mem [MAX_ITEMS];
    t_tail r_rd_data;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_mid, n_mid;
    t_tail         r_key, n_key;
    logic          r_last, n_last;
    logic [CW-1:0] r_run_length, n_run_length;
    logic [CW-1:0] r_item_count, n_item_count;
    logic          r_overflowed, n_overflowed;
    logic          r_out_valid, n_out_valid;
    t_len          r_out_len, n_out_len;
    logic          r_out_ovf, n_out_ovf;

    logic [CW-1:0] mid_calc;
    logic          mem_re;
    logic          mem_we;

    assign mid_calc = r_lo + ((r_hi - r_lo) >> 1);

    always_comb begin
        n_state      = r_state;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_key        = r_key;
        n_last       = r_last;
        n_run_length = r_run_length;
        n_item_count = r_item_count;
        n_overflowed = r_overflowed;
        n_out_valid  = r_out_valid;
        n_out_len    = r_out_len;
        n_out_ovf    = r_out_ovf;
        mem_re       = 1'b0;
        mem_we       = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key  = $unsigned(i_value) ^ SIGN_FLIP;
                    n_last = i_last;
                    if (r_item_count < CNT_MAX) begin
                        n_lo    = '0;
                        n_hi    = r_run_length;
                        n_state = S_PROBE;
                    end else begin
                        n_overflowed = 1'b1;
                        n_state      = i_last ? S_FINISH : S_IDLE;
                    end
                end
            end
            S_PROBE: begin
                if (r_lo < r_hi) begin
                    n_mid   = mid_calc;
                    mem_re  = 1'b1;
                    n_state = S_CMP;
                end else begin
                    n_state = S_UPDATE;
                end
            end
            S_CMP: begin
                if (r_rd_data < r_key) begin
                    n_lo = r_mid + 1'b1;
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_PROBE;
            end
            S_UPDATE: begin
                mem_we = (r_lo < CNT_MAX);
                if (r_lo == r_run_length) begin
                    n_run_length = r_run_length + 1'b1;
                end
                n_item_count = r_item_count + 1'b1;
                n_state      = r_last ? S_FINISH : S_IDLE;
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_len    = LEN_W'(r_run_length);
                    n_out_ovf    = r_overflowed;
                    n_run_length = '0;
                    n_item_count = '0;
                    n_overflowed = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_tail_mem[mid_calc[AW-1:0]];
        end
        if (mem_we) begin
            r_tail_mem[r_lo[AW-1:0]] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_run_length <= '0;
            r_item_count <= '0;
            r_overflowed <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_run_length <= n_run_length;
            r_item_count <= n_item_count;
            r_overflowed <= n_overflowed;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_key     <= n_key;
        r_last    <= n_last;
        r_out_len <= n_out_len;
        r_out_ovf <= n_out_ovf;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_lis_length = r_out_len;
    assign o_overflow   = r_out_ovf;

endmodule

@@ rtl/lis_checker.sv @@
module lis_assertions #(
    parameter int MAX_ITEMS = 1024
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          i_last,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input lis_pkg::t_len o_lis_length,
    input logic          o_overflow
);
    import lis_pkg::*;

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_lis_length) && $stable(o_overflow))
        else $error("result changed while stalled");

    // A closing input transaction keeps the block busy for at least the next cycle.
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_last |=> o_in_stall)
        else $error("input taken again right after a closing transaction");

    // A result only appears after the block has been working on an element.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a finished sequence");

    // Reported lengths are nonzero and stay within the table size.
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (MAX_ITEMS < 2048) |->
            (o_lis_length != '0) && (o_lis_length <= LEN_W'(MAX_ITEMS)))
        else $error("result length out of range");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind longest_increasing_subsequence lis_assertions #(.MAX_ITEMS(MAX_ITEMS)) u_lis_assertions (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_last       (i_last),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_lis_length (o_lis_length),
    .o_overflow   (o_overflow)
);

@@ tb/lis_checker.sv @@
`timescale 1ns / 1ps

module lis_checker #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic signed [31:0]   i_value,
    input  logic                 i_last,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  lis_pkg::t_len        i_lis_length,
    input  logic                 i_overflow,
    output int                   o_fail_count,
    output int                   o_pending
);
    import lis_pkg::*;

    typedef struct packed {
        t_len length;
        logic overflow;
    } t_lis_result;

    // Tails are kept with the sign bit flipped, so unsigned order is signed order.
    t_tail       tail_table [MAX_ITEMS];
    int          table_len = 0;
    int          elem_count = 0;
    logic        dropped = 1'b0;
    t_lis_result lis_results_due [$];
    int          fail_count = 0;
    int          pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic absorb_element(input logic signed [31:0] elem, input logic is_last);
        t_tail       key;
        int          lo;
        int          hi;
        int          mid;
        t_lis_result res;
        key = elem ^ SIGN_FLIP;
        if (elem_count < MAX_ITEMS) begin
            lo = 0;
            hi = table_len;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (tail_table[mid] < key) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
            tail_table[lo] = key;
            if (lo == table_len) begin
                table_len++;
            end
            elem_count++;
        end else begin
            dropped = 1'b1;
        end
        if (is_last) begin
            res.length   = t_len'(table_len);
            res.overflow = dropped;
            lis_results_due.push_back(res);
            pending_count++;
            table_len  = 0;
            elem_count = 0;
            dropped    = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_lis_result want;
        if (!i_rst_n) begin
            table_len  = 0;
            elem_count = 0;
            dropped    = 1'b0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                absorb_element(i_value, i_last);
            end
            if (i_out_valid && !i_out_stall) begin
                if (lis_results_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result length %0d overflow %0b",
                                              i_lis_length, i_overflow));
                end else begin
                    want = lis_results_due.pop_front();
                    pending_count--;
                    if (i_lis_length !== want.length) begin
                        report_mismatch($sformatf("lis_length got %0d expected %0d",
                                                  i_lis_length, want.length));
                    end
                    if (i_overflow !== want.overflow) begin
                        report_mismatch($sformatf("overflow got %0b expected %0b",
                                                  i_overflow, want.overflow));
                    end
                end
            end
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import lis_pkg::*;

    localparam int MAX_ITEMS        = 1024;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int DRAIN_CYCLES     = 64;
    localparam int HOLD_CYCLES      = 400;
    localparam int PRESSURE_SINGLES = 40;
    localparam int PHASE_ITEMS      = 160;

    typedef enum int {FILL_ANY, FILL_NARROW, FILL_RISING, FILL_FALLING} t_fill_style;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] value = '0;
    logic               last = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_len               lis_length;
    logic               overflow;

    int                 fail_count;
    int                 pending;
    int                 tx_idle_pct = 13;
    int                 rx_idle_pct = 57;
    logic               hold_start = 1'b0;
    logic               hold_used = 1'b0;
    int                 hold_left = 0;
    int                 quiet_cycles = 0;
    int                 items_sent = 0;
    logic signed [31:0] seq_buf [$];

    always #4 clk = ~clk;

    longest_increasing_subsequence #(
        .MAX_ITEMS(MAX_ITEMS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_value     (value),
        .i_last      (last),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_lis_length(lis_length),
        .o_overflow  (overflow)
    );

    lis_checker #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_value     (value),
        .i_last      (last),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_lis_length(lis_length),
        .i_overflow  (overflow),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // The receiver may be told once to hold off for a long stretch, so that the
    // block fills up and pushes back on its input.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_start && !hold_used) begin
            out_stall <= 1'b1;
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic offer_element(input logic signed [31:0] elem, input logic is_last);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= elem;
        last     <= is_last;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic send_buffer();
        int k;
        for (k = 0; k < seq_buf.size(); k++) begin
            offer_element(seq_buf[k], k == seq_buf.size() - 1);
        end
        seq_buf.delete();
    endtask

    task automatic build_random_sequence();
        int                 len;
        int                 k;
        t_fill_style        style;
        logic signed [31:0] v;
        case ($urandom_range(9))
            0: len = 1;
            1, 2: len = $urandom_range(64, 17);
            default: len = $urandom_range(16, 2);
        endcase
        style = t_fill_style'($urandom_range(3));
        v = $urandom;
        for (k = 0; k < len; k++) begin
            case (style)
                FILL_ANY: v = $urandom;
                FILL_NARROW: v = $signed($urandom_range(15)) - 8;
                FILL_RISING: v = v + $signed($urandom_range(200)) - 40;
                default: v = v - $signed($urandom_range(200)) + 40;
            endcase
            seq_buf.push_back(v);
        end
    endtask

    task automatic run_random_phase(input int target);
        int stop_at;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            build_random_sequence();
            send_buffer();
        end
    endtask

    initial begin
        int                 k;
        logic signed [31:0] v;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes, sign crossing, equal values, a falling run and a textbook mix.
        seq_buf = '{32'sh8000_0000};
        send_buffer();
        seq_buf = '{32'sh7fff_ffff};
        send_buffer();
        seq_buf = '{32'sh8000_0000, 32'sh7fff_ffff};
        send_buffer();
        seq_buf = '{32'sh7fff_ffff, 32'sh8000_0000};
        send_buffer();
        seq_buf = '{5, 5, 5};
        send_buffer();
        seq_buf = '{3, 2, 1};
        send_buffer();
        seq_buf = '{-1, 0, 1};
        send_buffer();
        seq_buf = '{10, 9, 2, 5, 3, 7, 101, 18};
        send_buffer();

        run_random_phase(PHASE_ITEMS);

        // Single-element sequences against a long receiver hold-off.
        hold_start <= 1'b1;
        for (k = 0; k < PRESSURE_SINGLES; k++) begin
            seq_buf.push_back($urandom);
            send_buffer();
        end

        tx_idle_pct <= 57;
        rx_idle_pct <= 13;
        run_random_phase(PHASE_ITEMS);

        tx_idle_pct <= 0;
        rx_idle_pct <= 0;

        // A strictly rising run that fills the table, then dropped elements,
        // the last of which closes the sequence.
        v = 32'sh8000_0000 + $signed($urandom_range(1000));
        for (k = 0; k < MAX_ITEMS; k++) begin
            seq_buf.push_back(v);
            v = v + $signed($urandom_range(1000000, 1));
        end
        k = $urandom_range(3, 1);
        while (k > 0) begin
            seq_buf.push_back($urandom);
            k--;
        end
        send_buffer();

        run_random_phase(PHASE_ITEMS / 2);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
